FILE: design/pocc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pocc_pkg;

    localparam int COORD_W = 16;
    localparam int LEN_W   = 15;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_BOX    = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    localparam logic [1:0] BLK_NONE   = 2'd0;
    localparam logic [1:0] BLK_BOX    = 2'd1;
    localparam logic [1:0] BLK_SPHERE = 2'd2;

    localparam logic REG_MARGIN         = 1'b0;
    localparam logic REG_DEFAULT_RADIUS = 1'b1;

    localparam logic [LEN_W-1:0] MARGIN_RST         = 15'd90;
    localparam logic [LEN_W-1:0] DEFAULT_RADIUS_RST = 15'd307;

    typedef struct packed {
        logic [LEN_W-1:0] margin;
        logic [LEN_W-1:0] default_radius;
    } t_cfg;

    typedef struct packed {
        logic       is_free;
        logic [1:0] blocked_by;
        logic       sphere_overflow;
    } t_result;

endpackage

`default_nettype wire

FILE: design/pocc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pocc_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [2:0]         slot;
    logic               entry_valid;
    logic               new_list;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [14:0]        half_x;
    logic [14:0]        half_y;
    logic [14:0]        half_z;
    logic signed [15:0] sphere_radius;

    modport source (
        output valid, command, slot, entry_valid, new_list,
               pos_x, pos_y, pos_z, half_x, half_y, half_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, command, slot, entry_valid, new_list,
               pos_x, pos_y, pos_z, half_x, half_y, half_z, sphere_radius,
        output ready
    );
endinterface

interface pocc_result_if;
    logic       valid;
    logic       ready;
    logic       is_free;
    logic [1:0] blocked_by;
    logic       sphere_overflow;

    modport source (
        output valid, is_free, blocked_by, sphere_overflow,
        input  ready
    );
    modport sink (
        input  valid, is_free, blocked_by, sphere_overflow,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/pocc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pocc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/pocc_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pocc_apb_regs import pocc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [LEN_W-1:0] r_margin;
    logic [LEN_W-1:0] r_default_radius;
    logic             w_wr;
    logic             w_sel;

    // Registers sit 4 bytes apart, so the word index is the top address bit.
    assign w_sel  = paddr[PADDR_W-1];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin         <= MARGIN_RST;
            r_default_radius <= DEFAULT_RADIUS_RST;
        end else if (w_wr) begin
            unique case (w_sel)
                REG_MARGIN:         r_margin         <= pwdata[LEN_W-1:0];
                REG_DEFAULT_RADIUS: r_default_radius <= pwdata[LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_MARGIN:         prdata = {{(PDATA_W-LEN_W){1'b0}}, r_margin};
            REG_DEFAULT_RADIUS: prdata = {{(PDATA_W-LEN_W){1'b0}}, r_default_radius};
        endcase
    end

    assign o_cfg.margin         = r_margin;
    assign o_cfg.default_radius = r_default_radius;

endmodule

`default_nettype wire

FILE: design/pocc_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module pocc_engine import pocc_pkg::*; #(
    parameter int MAX_BOXES   = 8,
    parameter int MAX_SPHERES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    pocc_item_if.sink  i_item,
    output logic       o_res_valid,
    output t_result    o_res,
    input  logic       i_res_ready
);

    localparam int BOX_AW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int SPH_AW     = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int SCAN_LEN   = (MAX_BOXES > MAX_SPHERES) ? MAX_BOXES : MAX_SPHERES;
    localparam int IW         = $clog2(SCAN_LEN + 1);
    localparam int CW         = $clog2(MAX_SPHERES + 1);
    localparam int SLOT_EXT_W = BOX_AW + 3;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam logic [1:0] PIPE_TAIL = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [LEN_W-1:0]          hx;
        logic [LEN_W-1:0]          hy;
        logic [LEN_W-1:0]          hz;
    } t_box_entry;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [LEN_W-1:0]          radius;
    } t_sph_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    endfunction

    t_state                    r_state;
    logic [IW-1:0]             r_idx;
    logic [1:0]                r_drain;
    logic [MAX_BOXES-1:0]      r_box_en;
    logic [CW-1:0]             r_sph_count;
    logic                      r_ovf;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [COORD_W-1:0] r_pz;

    logic                      w_take;
    logic                      w_box_cmd;
    logic                      w_sph_cmd;
    logic                      w_query;
    logic                      w_slot_ok;
    logic [SLOT_EXT_W-1:0]     w_slot_ext;
    logic [BOX_AW-1:0]         w_slot_addr;
    logic [CW-1:0]             w_sph_base;
    logic                      w_sph_room;
    logic [LEN_W-1:0]          w_radius;
    t_box_entry                w_box_wr;
    t_sph_entry                w_sph_wr;
    t_box_entry                w_box_rd;
    t_sph_entry                w_sph_rd;
    logic                      w_box_rv;
    logic                      w_sph_rv;

    assign i_item.ready = (r_state == ST_IDLE);
    assign w_take       = i_item.valid & i_item.ready;

    always_comb begin
        w_box_cmd = 1'b0;
        w_sph_cmd = 1'b0;
        w_query   = 1'b0;
        if (w_take) begin
            unique case (t_cmd'(i_item.command))
                CMD_BOX:    w_box_cmd = 1'b1;
                CMD_SPHERE: w_sph_cmd = 1'b1;
                CMD_QUERY:  w_query   = 1'b1;
                default:    ;
            endcase
        end
    end

    assign w_slot_ok   = 32'(i_item.slot) < MAX_BOXES;
    assign w_slot_ext  = SLOT_EXT_W'(i_item.slot);
    assign w_slot_addr = w_slot_ext[BOX_AW-1:0];

    // A new list restarts at entry zero, so its first sphere always finds room.
    assign w_sph_base = i_item.new_list ? '0 : r_sph_count;
    assign w_sph_room = w_sph_base < CW'(MAX_SPHERES);
    assign w_radius   = (i_item.sphere_radius > 16'sd0) ? i_item.sphere_radius[LEN_W-1:0]
                                                        : i_cfg.default_radius;

    assign w_box_wr.cx = i_item.pos_x;
    assign w_box_wr.cy = i_item.pos_y;
    assign w_box_wr.cz = i_item.pos_z;
    assign w_box_wr.hx = i_item.half_x;
    assign w_box_wr.hy = i_item.half_y;
    assign w_box_wr.hz = i_item.half_z;

    assign w_sph_wr.cx     = i_item.pos_x;
    assign w_sph_wr.cy     = i_item.pos_y;
    assign w_sph_wr.cz     = i_item.pos_z;
    assign w_sph_wr.radius = w_radius;

    // Both tables are scanned in lockstep; writes only land while idle, so a
    // scan never meets a pending write to the same entry.
    pocc_ram #(
        .WIDTH ($bits(t_box_entry)),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_box_cmd & w_slot_ok & i_item.entry_valid),
        .i_wr_addr (w_slot_addr),
        .i_wr_data (w_box_wr),
        .i_rd_addr (r_idx[BOX_AW-1:0]),
        .o_rd_data (w_box_rd)
    );

    pocc_ram #(
        .WIDTH ($bits(t_sph_entry)),
        .DEPTH (MAX_SPHERES)
    ) u_sph_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_sph_cmd & w_sph_room),
        .i_wr_addr (w_sph_base[SPH_AW-1:0]),
        .i_wr_data (w_sph_wr),
        .i_rd_addr (r_idx[SPH_AW-1:0]),
        .o_rd_data (w_sph_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_en    <= '0;
            r_sph_count <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (w_box_cmd && w_slot_ok) begin
                r_box_en[w_slot_addr] <= i_item.entry_valid;
            end
            if (w_sph_cmd) begin
                r_sph_count <= w_sph_room ? CW'(w_sph_base + 1'b1) : w_sph_base;
                if (!w_sph_room) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px <= i_item.pos_x;
            r_py <= i_item.pos_y;
            r_pz <= i_item.pos_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_drain <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_query) begin
                        r_state <= ST_SCAN;
                        r_idx   <= '0;
                    end
                end
                ST_SCAN: begin
                    if (r_idx == IW'(SCAN_LEN - 1)) begin
                        r_state <= ST_DRAIN;
                        r_drain <= PIPE_TAIL;
                    end else begin
                        r_idx <= IW'(r_idx + 1'b1);
                    end
                end
                ST_DRAIN: begin
                    if (r_drain == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_drain <= r_drain - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Read issue: which of the two entries addressed this cycle take part.
    assign w_box_rv = (r_state == ST_SCAN) && (r_idx < IW'(MAX_BOXES)) &&
                      r_box_en[r_idx[BOX_AW-1:0]];
    assign w_sph_rv = (r_state == ST_SCAN) && (32'(r_idx) < 32'(r_sph_count));

    logic                 r_v1_box;
    logic                 r_v1_sph;
    logic                 r_v2;
    logic                 r_v3;
    logic                 r_box_hit;
    logic                 r_sph_hit;
    logic [COORD_W-1:0]   r_dx;
    logic [COORD_W-1:0]   r_dy;
    logic [COORD_W-1:0]   r_dz;
    logic [COORD_W-1:0]   r_rsum;
    logic [SQ_W-1:0]      r_sqx;
    logic [SQ_W-1:0]      r_sqy;
    logic [SQ_W-1:0]      r_sqz;
    logic [SQ_W-1:0]      r_rr;

    logic [COORD_W-1:0]   w_adx;
    logic [COORD_W-1:0]   w_ady;
    logic [COORD_W-1:0]   w_adz;
    logic [COORD_W-1:0]   w_limx;
    logic [COORD_W-1:0]   w_limy;
    logic [COORD_W-1:0]   w_limz;
    logic                 w_box_in;
    logic [SUM_W-1:0]     w_dist;
    logic                 w_sph_in;

    // Box test: strict inside on every axis of the box grown by the margin.
    assign w_adx    = abs_diff(r_px, w_box_rd.cx);
    assign w_ady    = abs_diff(r_py, w_box_rd.cy);
    assign w_adz    = abs_diff(r_pz, w_box_rd.cz);
    assign w_limx   = {1'b0, w_box_rd.hx} + {1'b0, i_cfg.margin};
    assign w_limy   = {1'b0, w_box_rd.hy} + {1'b0, i_cfg.margin};
    assign w_limz   = {1'b0, w_box_rd.hz} + {1'b0, i_cfg.margin};
    assign w_box_in = (w_adx < w_limx) && (w_ady < w_limy) && (w_adz < w_limz);

    assign w_dist   = SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);
    assign w_sph_in = w_dist < SUM_W'(r_rr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_box  <= 1'b0;
            r_v1_sph  <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_box_hit <= 1'b0;
            r_sph_hit <= 1'b0;
        end else begin
            r_v1_box <= w_box_rv;
            r_v1_sph <= w_sph_rv;
            r_v2     <= r_v1_sph;
            r_v3     <= r_v2;
            if (w_query) begin
                r_box_hit <= 1'b0;
                r_sph_hit <= 1'b0;
            end else begin
                if (r_v1_box && w_box_in) begin
                    r_box_hit <= 1'b1;
                end
                if (r_v3 && w_sph_in) begin
                    r_sph_hit <= 1'b1;
                end
            end
        end
    end

    // Sphere test: deltas and radius sum, then squares, then the compare.
    always_ff @(posedge i_clk) begin
        r_dx   <= abs_diff(r_px, w_sph_rd.cx);
        r_dy   <= abs_diff(r_py, w_sph_rd.cy);
        r_dz   <= abs_diff(r_pz, w_sph_rd.cz);
        r_rsum <= {1'b0, w_sph_rd.radius} + {1'b0, i_cfg.margin};
        r_sqx  <= r_dx * r_dx;
        r_sqy  <= r_dy * r_dy;
        r_sqz  <= r_dz * r_dz;
        r_rr   <= r_rsum * r_rsum;
    end

    assign o_res_valid           = (r_state == ST_DONE);
    assign o_res.is_free         = !(r_box_hit || r_sph_hit);
    assign o_res.blocked_by      = r_box_hit ? BLK_BOX : (r_sph_hit ? BLK_SPHERE : BLK_NONE);
    assign o_res.sphere_overflow = r_ovf;

    a_pipe_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1_box || r_v1_sph) |-> (r_state == ST_SCAN || r_state == ST_DRAIN))
        else $error("scan pipeline holds an entry outside a scan");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_v1_box && !r_v1_sph && !r_v2 && !r_v3))
        else $error("result offered before the scan pipeline drained");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sph_count <= CW'(MAX_SPHERES))
        else $error("sphere count beyond capacity");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    a_query_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> (!r_box_hit && !r_sph_hit))
        else $error("hit flags not cleared at query start");

endmodule

`default_nettype wire

FILE: design/point_obstacle_collision_check_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Port        Payload
// item       in         i_item      command, slot, entry_valid, new_list, pos_*, half_*,
//                                   sphere_radius
// result     out        o_result    is_free, blocked_by, sphere_overflow
// registers  in/out     APB (psel)  margin at 0x0, default_radius at 0x4
//
// Box writes and sphere appends give no result.
// A query holds the engine until its result reaches the output register: the box and
// sphere memories are read in lockstep, one entry per cycle, through a four-stage tail.
// Reset is synchronous and active low; it clears box enables, sphere count and the flag.
// A result waits in the output register while the next item is already being taken;
// a query stalls only when that register is still full as its own result is ready.

module point_obstacle_collision_check_core import pocc_pkg::*; #(
    parameter int MAX_BOXES   = 8,
    parameter int MAX_SPHERES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pocc_item_if.sink          i_item,
    pocc_result_if.source      o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    w_cfg;
    logic    w_eng_valid;
    t_result w_eng_res;
    logic    w_res_ready;
    logic    r_out_valid;
    t_result r_out;

    pocc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pocc_engine #(
        .MAX_BOXES   (MAX_BOXES),
        .MAX_SPHERES (MAX_SPHERES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item      (i_item),
        .o_res_valid (w_eng_valid),
        .o_res       (w_eng_res),
        .i_res_ready (w_res_ready)
    );

    assign w_res_ready = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_eng_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eng_valid && w_res_ready) begin
            r_out <= w_eng_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.is_free         = r_out.is_free;
    assign o_result.blocked_by      = r_out.blocked_by;
    assign o_result.sphere_overflow = r_out.sphere_overflow;

endmodule

`default_nettype wire

FILE: sim/pocc_checker.sv
`timescale 1ns / 1ps

module pocc_checker import pocc_pkg::*; #(
    parameter int MAX_BOXES   = 8,
    parameter int MAX_SPHERES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pocc_item_if               i_item,
    pocc_result_if             i_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_box_hits,
    output int                 o_sphere_hits
);

    t_cfg    cfg;
    int      box_cx [MAX_BOXES];
    int      box_cy [MAX_BOXES];
    int      box_cz [MAX_BOXES];
    int      box_hx [MAX_BOXES];
    int      box_hy [MAX_BOXES];
    int      box_hz [MAX_BOXES];
    bit      box_on [MAX_BOXES];
    int      sph_x  [MAX_SPHERES];
    int      sph_y  [MAX_SPHERES];
    int      sph_z  [MAX_SPHERES];
    int      sph_r  [MAX_SPHERES];
    int      sph_count;
    bit      overflow_seen;
    t_result pending_verdicts[$];

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Boxes are scanned before spheres; the first hit decides the verdict.
    function automatic t_result judge_point(int px, int py, int pz);
        t_result    verdict;
        logic [1:0] hit;
        longint     m;
        longint     dx;
        longint     dy;
        longint     dz;
        longint     reach;
        hit = BLK_NONE;
        m   = longint'(cfg.margin);
        for (int i = 0; i < MAX_BOXES; i++) begin
            if (hit == BLK_NONE && box_on[i]) begin
                if (mag(longint'(px) - box_cx[i]) < box_hx[i] + m &&
                    mag(longint'(py) - box_cy[i]) < box_hy[i] + m &&
                    mag(longint'(pz) - box_cz[i]) < box_hz[i] + m)
                    hit = BLK_BOX;
            end
        end
        for (int i = 0; i < sph_count; i++) begin
            if (hit == BLK_NONE) begin
                dx    = longint'(px) - sph_x[i];
                dy    = longint'(py) - sph_y[i];
                dz    = longint'(pz) - sph_z[i];
                reach = longint'(sph_r[i]) + m;
                if (dx * dx + dy * dy + dz * dz < reach * reach)
                    hit = BLK_SPHERE;
            end
        end
        verdict.is_free         = (hit == BLK_NONE);
        verdict.blocked_by      = hit;
        verdict.sphere_overflow = overflow_seen;
        return verdict;
    endfunction

    task automatic absorb_item();
        int s;
        int r;
        s = i_item.slot;
        if (i_item.command == CMD_BOX) begin
            if (s < MAX_BOXES) begin
                box_on[s] = i_item.entry_valid;
                if (i_item.entry_valid) begin
                    box_cx[s] = i_item.pos_x;
                    box_cy[s] = i_item.pos_y;
                    box_cz[s] = i_item.pos_z;
                    box_hx[s] = i_item.half_x;
                    box_hy[s] = i_item.half_y;
                    box_hz[s] = i_item.half_z;
                end
            end
        end else if (i_item.command == CMD_SPHERE) begin
            r = i_item.sphere_radius;
            if (i_item.new_list)
                sph_count = 0;
            if (sph_count < MAX_SPHERES) begin
                sph_x[sph_count] = i_item.pos_x;
                sph_y[sph_count] = i_item.pos_y;
                sph_z[sph_count] = i_item.pos_z;
                sph_r[sph_count] = (r > 0) ? r : int'(cfg.default_radius);
                sph_count++;
            end else begin
                overflow_seen = 1'b1;
            end
        end else if (i_item.command == CMD_QUERY) begin
            pending_verdicts = {pending_verdicts,
                                judge_point(i_item.pos_x, i_item.pos_y, i_item.pos_z)};
        end
    endtask

    task automatic check_result();
        t_result want;
        if (pending_verdicts.size() == 0) begin
            $error("result transfer with no query waiting: is_free=%0d blocked_by=%0d",
                   i_result.is_free, i_result.blocked_by);
            o_fail_count++;
        end else begin
            want = pending_verdicts.pop_front();
            if (i_result.is_free !== want.is_free) begin
                $error("is_free: expected %0d, got %0d", want.is_free, i_result.is_free);
                o_fail_count++;
            end
            if (i_result.blocked_by !== want.blocked_by) begin
                $error("blocked_by: expected %0d, got %0d", want.blocked_by, i_result.blocked_by);
                o_fail_count++;
            end
            if (i_result.sphere_overflow !== want.sphere_overflow) begin
                $error("sphere_overflow: expected %0d, got %0d",
                       want.sphere_overflow, i_result.sphere_overflow);
                o_fail_count++;
            end
            o_checked++;
            if (want.blocked_by == BLK_BOX)
                o_box_hits++;
            else if (want.blocked_by == BLK_SPHERE)
                o_sphere_hits++;
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_checked     = 0;
        o_box_hits    = 0;
        o_sphere_hits = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.margin         = MARGIN_RST;
            cfg.default_radius = DEFAULT_RADIUS_RST;
            for (int i = 0; i < MAX_BOXES; i++)
                box_on[i] = 1'b0;
            sph_count     = 0;
            overflow_seen = 1'b0;
            pending_verdicts.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[PADDR_W-1:2] == REG_DEFAULT_RADIUS)
                    cfg.default_radius = pwdata[LEN_W-1:0];
                else
                    cfg.margin = pwdata[LEN_W-1:0];
            end
            if (i_result.valid && i_result.ready)
                check_result();
            if (i_item.valid && i_item.ready)
                absorb_item();
        end
        o_pending = pending_verdicts.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench import pocc_pkg::*; ();

    localparam int         STALL_LIMIT = 4000;
    // Longest query walk plus some slack for the output register.
    localparam int         QUERY_TAIL  = 45;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct {
        logic [1:0]         command;
        logic [2:0]         slot;
        logic               entry_valid;
        logic               new_list;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [14:0]        half_x;
        logic [14:0]        half_y;
        logic [14:0]        half_z;
        logic signed [15:0] sphere_radius;
    } t_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               item_taken = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int box_hits;
    int sphere_hits;
    int items_sent = 0;
    int burst_left = 0;
    int stall_cycles = 0;
    int rx_cycle = 0;
    int rx_mode = 0;
    int cur_drone = int'(MARGIN_RST);
    int cur_default = int'(DEFAULT_RADIUS_RST);
    int drone_plan[6];
    int default_plan[6];
    int phase_start;

    // Obstacles of the current scene, used to aim queries near their borders.
    int aim_x[$];
    int aim_y[$];
    int aim_z[$];
    int aim_sx[$];
    int aim_sy[$];
    int aim_sz[$];

    pocc_item_if   item_ch ();
    pocc_result_if result_ch ();

    point_obstacle_collision_check_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pocc_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item_ch),
        .i_result      (result_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_box_hits    (box_hits),
        .o_sphere_hits (sphere_hits)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        item_taken <= item_ch.valid && item_ch.ready;
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // The result side cycles through always ready, coin flips, a fixed duty
    // pattern and a mostly stalled mode with rare random ready.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_cycle % 150 == 0)
                rx_mode = $urandom_range(0, 3);
            rx_cycle++;
            case (rx_mode)
                0:       result_ch.ready = 1'b1;
                1:       result_ch.ready = 1'($urandom_range(0, 1));
                2:       result_ch.ready = (rx_cycle % 9) < 4;
                default: result_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int rand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.command       = 2'($urandom_range(0, 3));
        it.slot          = 3'($urandom_range(0, 7));
        it.entry_valid   = 1'($urandom_range(0, 1));
        it.new_list      = 1'($urandom_range(0, 1));
        it.pos_x         = 16'($urandom_range(0, 65535));
        it.pos_y         = 16'($urandom_range(0, 65535));
        it.pos_z         = 16'($urandom_range(0, 65535));
        it.half_x        = 15'($urandom_range(0, 32767));
        it.half_y        = 15'($urandom_range(0, 32767));
        it.half_z        = 15'($urandom_range(0, 32767));
        it.sphere_radius = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic int rand_centre();
        if ($urandom_range(0, 9) == 0)
            return rand16();
        return int'($urandom_range(0, 16000)) - 8000;
    endfunction

    function automatic int rand_half();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 32767);
        return $urandom_range(0, 1500);
    endfunction

    function automatic int rand_radius();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return -int'($urandom_range(1, 32768));
            2:       return $urandom_range(1, 32767);
            default: return $urandom_range(1, 1500);
        endcase
    endfunction

    // Lands on the border, one step inside it, or anywhere in a band around it.
    function automatic int aim_coord(int c, int s);
        int v;
        case ($urandom_range(0, 7))
            0:       v = c + s;
            1:       v = c - s;
            2:       v = c + s - 1;
            3:       v = c - s + 1;
            default: v = c + int'($urandom_range(0, 3 * s + 2)) - (3 * s + 2) / 2;
        endcase
        return clamp16(v);
    endfunction

    task automatic drive_item(t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                5:       gap = $urandom_range(10, 40);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                item_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        item_ch.command       = it.command;
        item_ch.slot          = it.slot;
        item_ch.entry_valid   = it.entry_valid;
        item_ch.new_list      = it.new_list;
        item_ch.pos_x         = it.pos_x;
        item_ch.pos_y         = it.pos_y;
        item_ch.pos_z         = it.pos_z;
        item_ch.half_x        = it.half_x;
        item_ch.half_y        = it.half_y;
        item_ch.half_z        = it.half_z;
        item_ch.sphere_radius = it.sphere_radius;
        item_ch.valid         = 1'b1;
        do @(negedge i_clk); while (!item_taken);
        items_sent++;
    endtask

    task automatic put_box(int slot, bit en, int x, int y, int z, int hx, int hy, int hz);
        t_item it;
        it             = random_item();
        it.command     = CMD_BOX;
        it.slot        = 3'(slot);
        it.entry_valid = en;
        if (en) begin
            it.pos_x  = 16'(x);
            it.pos_y  = 16'(y);
            it.pos_z  = 16'(z);
            it.half_x = 15'(hx);
            it.half_y = 15'(hy);
            it.half_z = 15'(hz);
            aim_x  = {aim_x, x};
            aim_y  = {aim_y, y};
            aim_z  = {aim_z, z};
            aim_sx = {aim_sx, hx + cur_drone};
            aim_sy = {aim_sy, hy + cur_drone};
            aim_sz = {aim_sz, hz + cur_drone};
        end
        drive_item(it);
    endtask

    task automatic put_sphere(bit fresh, int x, int y, int z, int r);
        t_item it;
        int    reach;
        it               = random_item();
        it.command       = CMD_SPHERE;
        it.new_list      = fresh;
        it.pos_x         = 16'(x);
        it.pos_y         = 16'(y);
        it.pos_z         = 16'(z);
        it.sphere_radius = 16'(r);
        reach            = ((r > 0) ? r : cur_default) + cur_drone;
        aim_x  = {aim_x, x};
        aim_y  = {aim_y, y};
        aim_z  = {aim_z, z};
        aim_sx = {aim_sx, reach};
        aim_sy = {aim_sy, reach};
        aim_sz = {aim_sz, reach};
        drive_item(it);
    endtask

    task automatic put_query(int x, int y, int z);
        t_item it;
        it         = random_item();
        it.command = CMD_QUERY;
        it.pos_x   = 16'(x);
        it.pos_y   = 16'(y);
        it.pos_z   = 16'(z);
        drive_item(it);
    endtask

    task automatic aimed_query();
        int k;
        if (aim_x.size() == 0 || $urandom_range(0, 9) == 0) begin
            put_query(rand16(), rand16(), rand16());
        end else begin
            k = $urandom_range(0, aim_x.size() - 1);
            case ($urandom_range(0, 4))
                // Two coordinates on the centre probe a single face or pole.
                0:       put_query(aim_coord(aim_x[k], aim_sx[k]), aim_y[k], aim_z[k]);
                1:       put_query(aim_x[k], aim_y[k], aim_coord(aim_z[k], aim_sz[k]));
                default: put_query(aim_coord(aim_x[k], aim_sx[k]),
                                   aim_coord(aim_y[k], aim_sy[k]),
                                   aim_coord(aim_z[k], aim_sz[k]));
            endcase
        end
    endtask

    task automatic write_reg(logic index, int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(negedge i_clk); while (!pready);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Registers change only once every query has been answered and the
    // last walk has had time to drain.
    task automatic settle();
        item_ch.valid = 1'b0;
        burst_left    = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (QUERY_TAIL) @(negedge i_clk);
    endtask

    task automatic build_scene(bit fill_up);
        int nb;
        int ns;
        int nq;
        aim_x.delete();
        aim_y.delete();
        aim_z.delete();
        aim_sx.delete();
        aim_sy.delete();
        aim_sz.delete();
        nb = $urandom_range(0, 6);
        repeat (nb)
            put_box($urandom_range(0, 7), $urandom_range(0, 7) != 0, rand_centre(),
                    rand_centre(), rand_centre(), rand_half(), rand_half(), rand_half());
        ns = fill_up ? $urandom_range(36, 44) : $urandom_range(0, 10);
        for (int i = 0; i < ns; i++)
            put_sphere(i == 0 && (fill_up || $urandom_range(0, 7) != 0), rand_centre(),
                       rand_centre(), rand_centre(), rand_radius());
        nq = $urandom_range(8, 30);
        repeat (nq) begin
            if ($urandom_range(0, 11) == 0)
                drive_item(random_item());
            else
                aimed_query();
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_ch.valid         = 1'b0;
        item_ch.command       = CMD_BOX;
        item_ch.slot          = '0;
        item_ch.entry_valid   = 1'b0;
        item_ch.new_list      = 1'b0;
        item_ch.pos_x         = '0;
        item_ch.pos_y         = '0;
        item_ch.pos_z         = '0;
        item_ch.half_x        = '0;
        item_ch.half_y        = '0;
        item_ch.half_z        = '0;
        item_ch.sphere_radius = '0;
        drone_plan   = '{90, 0, 32767, $urandom_range(0, 32767), 1, $urandom_range(0, 600)};
        default_plan = '{307, 0, 32767, $urandom_range(0, 32767), 1, $urandom_range(0, 600)};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty tables, unused command, box borders, disabling,
        // sphere borders, default radius, box priority and list clearing.
        put_query(-32768, 32767, 0);
        begin
            t_item junk;
            junk         = random_item();
            junk.command = CMD_UNUSED;
            drive_item(junk);
        end
        put_box(0, 1, 0, 0, 0, 100, 100, 100);
        put_query(189, 0, 0);
        put_query(190, 0, 0);
        put_query(-189, -189, 189);
        put_box(0, 0, 0, 0, 0, 0, 0, 0);
        put_query(0, 0, 0);
        put_box(0, 1, 0, 0, 0, 100, 100, 100);
        put_box(7, 1, -32768, -32768, -32768, 32767, 32767, 32767);
        put_query(32767, 32767, 32767);
        put_query(-300, -300, -300);
        put_sphere(1, 1000, 0, 0, 100);
        put_query(1189, 0, 0);
        put_query(1190, 0, 0);
        put_sphere(0, -1000, -1000, -1000, 0);
        put_query(-1000, -1000, -604);
        put_query(-1000, -1000, -603);
        put_sphere(0, 5000, 5000, 5000, -32768);
        put_sphere(0, 20000, -20000, 20000, 32767);
        put_query(20000, -20000, 20000);
        put_sphere(1, 0, 0, 0, 500);
        put_query(0, 0, 0);
        put_query(1000, 0, 0);
        put_box(7, 0, 0, 0, 0, 0, 0, 0);

        // Random scenes under six register settings; the fourth one
        // overfills the sphere list.
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            write_reg(REG_MARGIN, drone_plan[phase]);
            cur_drone = drone_plan[phase];
            write_reg(REG_DEFAULT_RADIUS, default_plan[phase]);
            cur_default = default_plan[phase];
            phase_start = items_sent;
            while (items_sent - phase_start < 250)
                build_scene(phase == 3 && items_sent == phase_start);
        end

        item_ch.valid = 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (QUERY_TAIL) @(negedge i_clk);
        $display("testbench: %0d items sent under six register settings, %0d queries checked",
                 items_sent, checked);
        $display("testbench: answers were %0d free, %0d box hits, %0d sphere hits",
                 checked - box_hits - sphere_hits, box_hits, sphere_hits);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
